// ===== design/pwbs_pkg.sv =====
// ============================================================================
// pwbs_pkg: shared types and constants of the pulse-width byte sender
// Register map codes, field widths and register reset values.
// ============================================================================
package pwbs_pkg;

   localparam int TICK_W = 16;
   localparam int CODE_W = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ENABLE   = 3'd0,
      REG_PREAMBLE = 3'd1,
      REG_START    = 3'd2,
      REG_SHORT    = 3'd3,
      REG_LONG     = 3'd4
   } reg_index_type;

   localparam logic [TICK_W-1:0] PREAMBLE_RESET = 16'd8000;
   localparam logic [TICK_W-1:0] START_RESET    = 16'd5000;
   localparam logic [TICK_W-1:0] SHORT_RESET    = 16'd170;
   localparam logic [TICK_W-1:0] LONG_RESET     = 16'd430;

endpackage

// ===== design/pulse_width_byte_sender.sv =====
// ============================================================================
// pulse_width_byte_sender: single-wire pulse-width code transmitter
// Ticks and send requests in, one status transfer out per item.
// ============================================================================
// Each request transfer (req_cmd = 1) asks to send req_code_byte; each tick
// transfer (req_cmd = 0) lets one microsecond pass. A taken request drives the
// line high for preamble_ticks, low for start_ticks, then BITS_PER_CODE bits
// LSB first (0: short high, long low; 1: long high, short low), then idles
// high. Every input transfer yields exactly one result transfer carrying the
// line level and busy flag after that item, plus accepted/refused/finished.
// Throughput is one item per clock while the result channel is not stalled:
// the item sits in an input register, a single pass of counter/phase logic
// updates the sender state and loads the result register.
// The input register can take a new item while a result waits to be taken.
// Registers sit on an APB port at byte address 4*index (enable, preamble,
// start, short, long); write them only while the sender is idle. A duration
// of zero acts as one tick.
// ============================================================================
module pulse_width_byte_sender #(
   parameter int BITS_PER_CODE = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [pwbs_pkg::CODE_W-1:0]         req_code_byte,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_line_level,
   output logic                                rsp_busy_res,
   output logic                                rsp_accepted,
   output logic                                rsp_refused,
   output logic                                rsp_finished,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pwbs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [pwbs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [pwbs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import pwbs_pkg::*;

   localparam int CNT_W = $clog2(BITS_PER_CODE + 1);

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_PRE   = 3'd1,
      PH_START = 3'd2,
      PH_BHIGH = 3'd3,
      PH_BLOW  = 3'd4
   } phase_type;

   // configuration registers
   logic              enable_ff;
   logic [TICK_W-1:0] preamble_ff, start_ff, short_ff, long_ff;
   logic              csr_write;
   reg_index_type     csr_index;

   // input register
   logic              in_valid_ff;
   logic              in_cmd_ff;
   logic [CODE_W-1:0] in_code_ff;

   // sender state
   phase_type                phase_ff, phase_in;
   logic [TICK_W-1:0]        tick_ff, tick_in;
   logic [BITS_PER_CODE-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]         left_ff, left_in;
   logic                     line_ff, line_in;

   // result register
   logic rsp_valid_ff;
   logic line_res_ff, busy_res_ff, acc_res_ff, ref_res_ff, fin_res_ff;

   logic              advance;
   logic              acc_in, ref_in, fin_in;
   logic [TICK_W-1:0] len_raw, phase_len;
   logic [TICK_W:0]   tick_sum;
   logic [31:0]       code_ext;
   logic [CNT_W-1:0]  left_dec;

   // ---------------------------------------------------------------------
   // Configuration port: no wait states, write on the access cycle.
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         preamble_ff <= PREAMBLE_RESET;
         start_ff    <= START_RESET;
         short_ff    <= SHORT_RESET;
         long_ff     <= LONG_RESET;
      end else if (csr_write) begin
         // addresses past the last register drop the write
         unique case (csr_index)
            REG_ENABLE:   enable_ff   <= pwdata[0];
            REG_PREAMBLE: preamble_ff <= pwdata[TICK_W-1:0];
            REG_START:    start_ff    <= pwdata[TICK_W-1:0];
            REG_SHORT:    short_ff    <= pwdata[TICK_W-1:0];
            REG_LONG:     long_ff     <= pwdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ENABLE:   prdata = {{(CSR_DATA_W-1){1'b0}}, enable_ff};
         REG_PREAMBLE: prdata = {{(CSR_DATA_W-TICK_W){1'b0}}, preamble_ff};
         REG_START:    prdata = {{(CSR_DATA_W-TICK_W){1'b0}}, start_ff};
         REG_SHORT:    prdata = {{(CSR_DATA_W-TICK_W){1'b0}}, short_ff};
         REG_LONG:     prdata = {{(CSR_DATA_W-TICK_W){1'b0}}, long_ff};
         default:      prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake: the input register moves into the result register whenever
   // the result register is empty or being drained this cycle.
   // ---------------------------------------------------------------------
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_cmd_ff  <= req_cmd;
         in_code_ff <= req_code_byte;
      end
   end

   // ---------------------------------------------------------------------
   // Length of the current phase; zero acts as one tick.
   // ---------------------------------------------------------------------
   always_comb begin
      unique case (phase_ff)
         PH_PRE:   len_raw = preamble_ff;
         PH_START: len_raw = start_ff;
         PH_BHIGH: len_raw = shift_ff[0] ? long_ff : short_ff;
         PH_BLOW:  len_raw = shift_ff[0] ? short_ff : long_ff;
         default:  len_raw = TICK_W'(1);
      endcase
      phase_len = (len_raw == '0) ? TICK_W'(1) : len_raw;
   end

   assign tick_sum = {1'b0, tick_ff} + (TICK_W+1)'(1);
   assign code_ext = 32'(in_code_ff);
   assign left_dec = (left_ff != '0) ? left_ff - CNT_W'(1) : left_ff;

   // ---------------------------------------------------------------------
   // Next state and result for the item in the input register.
   // ---------------------------------------------------------------------
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      line_in  = line_ff;
      acc_in   = 1'b0;
      ref_in   = 1'b0;
      fin_in   = 1'b0;
      if (in_cmd_ff) begin
         // send request: take it only when enabled and idle
         if (enable_ff && (phase_ff == PH_IDLE)) begin
            acc_in   = 1'b1;
            phase_in = PH_PRE;
            tick_in  = '0;
            shift_in = code_ext[BITS_PER_CODE-1:0];
            left_in  = CNT_W'(BITS_PER_CODE);
            line_in  = 1'b1;
         end else begin
            ref_in = 1'b1;
         end
      end else if (phase_ff != PH_IDLE) begin
         // tick: advance the counter, end the phase on wrap or length reached
         tick_in = tick_sum[TICK_W-1:0];
         if (tick_sum[TICK_W] || (tick_sum[TICK_W-1:0] >= phase_len)) begin
            tick_in = '0;
            unique case (phase_ff)
               PH_PRE: begin
                  phase_in = PH_START;
                  line_in  = 1'b0;
               end
               PH_START: begin
                  phase_in = PH_BHIGH;
                  line_in  = 1'b1;
               end
               PH_BHIGH: begin
                  phase_in = PH_BLOW;
                  line_in  = 1'b0;
               end
               PH_BLOW: begin
                  shift_in = shift_ff >> 1;
                  left_in  = left_dec;
                  line_in  = 1'b1;
                  if (left_dec == '0) begin
                     phase_in = PH_IDLE;
                     fin_in   = 1'b1;
                  end else begin
                     phase_in = PH_BHIGH;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         shift_ff <= '0;
         left_ff  <= '0;
         line_ff  <= 1'b1;
      end else if (advance) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         shift_ff <= shift_in;
         left_ff  <= left_in;
         line_ff  <= line_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register: hold until the transfer completes.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         line_res_ff <= line_in;
         busy_res_ff <= (phase_in != PH_IDLE);
         acc_res_ff  <= acc_in;
         ref_res_ff  <= ref_in;
         fin_res_ff  <= fin_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_level = line_res_ff;
   assign rsp_busy_res   = busy_res_ff;
   assign rsp_accepted   = acc_res_ff;
   assign rsp_refused    = ref_res_ff;
   assign rsp_finished   = fin_res_ff;

endmodule

// ===== design/pwbs_checker.sv =====
// ============================================================================
// pwbs_checker: port-level checks for the pulse-width byte sender
// Watches the result channel and its status flags over time.
// ============================================================================
module pwbs_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_line_level,
   input logic rsp_busy_res,
   input logic rsp_accepted,
   input logic rsp_refused,
   input logic rsp_finished
);

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_level)
         && $stable(rsp_busy_res) && $stable(rsp_accepted)
         && $stable(rsp_refused) && $stable(rsp_finished))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_refused))
      else $error("request both accepted and refused");

   // the last bit ends with the line released high and the sender idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> !rsp_busy_res && rsp_line_level
         && !rsp_accepted && !rsp_refused)
      else $error("finish without idle high line");

   // an idle sender always drives the line high
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_line_level)
      else $error("idle line not high");

   // a taken request starts the preamble: busy, line high
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_busy_res && rsp_line_level)
      else $error("accepted request did not start preamble");

endmodule

bind pulse_width_byte_sender pwbs_checker u_pwbs_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_line_level (rsp_line_level),
   .rsp_busy_res   (rsp_busy_res),
   .rsp_accepted   (rsp_accepted),
   .rsp_refused    (rsp_refused),
   .rsp_finished   (rsp_finished)
);
